// ----- rtl/core/mpq_pkg.sv -----
// Package for the multilevel process queue: operation, status and class codes,
// the item structures of both channels and the state-to-class mapping.
// Depends on nothing; every other file of the block imports it.
package mpq_pkg;

	// Operation codes of an input item
	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_REMOVE  = 2'd1,
		OP_DEQUEUE = 2'd2,
		OP_FIND    = 2'd3
	} op_t;

	// Status codes of a result item
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MISSING   = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_BAD_PRIO  = 2'd3
	} status_t;

	// Queue classes
	localparam logic [2:0] CLS_READY        = 3'd0;
	localparam logic [2:0] CLS_BLOCKED      = 3'd1;
	localparam logic [2:0] CLS_SUSP_READY   = 3'd2;
	localparam logic [2:0] CLS_SUSP_BLOCKED = 3'd3;
	localparam logic [2:0] CLS_OTHER        = 3'd4;

	// Execution and suspend state codes
	localparam logic [1:0] EX_READY     = 2'd0;
	localparam logic [1:0] EX_BLOCKED   = 2'd1;
	localparam logic [1:0] SU_ACTIVE    = 2'd0;
	localparam logic [1:0] SU_SUSPENDED = 2'd1;

	localparam int NUM_CLASSES = 5;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] proc_id;
		logic [1:0] exec_state;
		logic [1:0] suspend_state;
		logic [3:0] priority_req;
		logic [2:0] queue_class;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] out_proc_id;
		logic [2:0] out_class;
		logic [3:0] out_priority;
	} rsp_item_t;

	// Class of the list named by an execution state and a suspend state.
	function automatic logic [2:0] class_of(logic [1:0] ex, logic [1:0] su);
		logic [2:0] cls;
		cls = CLS_OTHER;
		if (ex == EX_READY) begin
			if (su == SU_SUSPENDED)
				cls = CLS_SUSP_READY;
			else if (su == SU_ACTIVE)
				cls = CLS_READY;
		end else if (ex == EX_BLOCKED) begin
			if (su == SU_SUSPENDED)
				cls = CLS_SUSP_BLOCKED;
			else if (su == SU_ACTIVE)
				cls = CLS_BLOCKED;
		end
		return cls;
	endfunction

endpackage

// ----- rtl/core/mpq_req_if.sv -----
// Request channel of the multilevel process queue: valid, ready and one item.
// Depends on mpq_pkg for the item structure.
interface mpq_req_if
	import mpq_pkg::*;
	;
	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/mpq_rsp_if.sv -----
// Result channel of the multilevel process queue: valid, ready and one item.
// Depends on mpq_pkg for the item structure.
interface mpq_rsp_if
	import mpq_pkg::*;
	;
	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/multilevel_process_queue_core.sv -----
// Multilevel process queue: an item is taken into the input register, worked
// out against the queue state in one pass and the result lands in the output
// register; one item is taken every cycle while the result channel is not stalled.
// The state update and the result share one clock edge per item.
// Reset empties every list and clears the handshake registers; no clearing pass.
module multilevel_process_queue_core
	import mpq_pkg::*;
#(
	parameter int NUM_PROCS      = 16,
	parameter int NUM_PRIORITIES = 10
) (
	input logic      clk,
	input logic      arst_n,
	mpq_req_if.sink  req,
	mpq_rsp_if.source rsp
);

	req_item_t item_s1;
	logic      valid_s1;
	rsp_item_t result;
	rsp_item_t rsp_q;
	logic      rsp_valid_q;
	logic      advance;
	logic      take;

	// The stage moves on when the output register is free or being emptied
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign take      = req.valid && req.ready;

	mpq_engine #(
		.NUM_PROCS      (NUM_PROCS),
		.NUM_PRIORITIES (NUM_PRIORITIES)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.result (result)
	);

	// Handshake state of the input and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// Item and result payload
	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= req.data;
		if (advance)
			rsp_q <= result;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule

// ----- rtl/core/mpq_engine.sv -----
// Queue state (entry table, per-id links, list heads and tails) and the
// single-pass logic that works out one operation and its state update.
// Depends on mpq_pkg.
module mpq_engine
	import mpq_pkg::*;
#(
	parameter int NUM_PROCS      = 16,
	parameter int NUM_PRIORITIES = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  req_item_t item,
	output rsp_item_t result
);

	localparam int IW        = $clog2(NUM_PROCS);
	localparam int LW        = $clog2(NUM_PROCS + 1);
	localparam int XW        = (IW > 4) ? IW : 4;
	localparam int NUM_LISTS = 2 * NUM_PRIORITIES + 3;
	localparam int LIW       = $clog2(NUM_LISTS);
	localparam logic [LW-1:0] NIL = LW'(NUM_PROCS);

	// Entry table: valid bits are control, class and priority are payload
	logic [NUM_PROCS-1:0] valid_q;
	logic [2:0]           cls_q  [NUM_PROCS];
	logic [3:0]           prio_q [NUM_PROCS];
	logic [LW-1:0]        next_q [NUM_PROCS];
	logic [LW-1:0]        prev_q [NUM_PROCS];
	logic [LW-1:0]        head_q [NUM_LISTS];
	logic [LW-1:0]        tail_q [NUM_LISTS];

	// List number of a class and priority.
	function automatic logic [LIW-1:0] list_of(logic [2:0] cls, logic [3:0] prio);
		logic [LIW-1:0] li;
		case (cls)
			CLS_READY:        li = LIW'(prio);
			CLS_SUSP_READY:   li = LIW'(NUM_PRIORITIES) + LIW'(prio);
			CLS_BLOCKED:      li = LIW'(2 * NUM_PRIORITIES);
			CLS_SUSP_BLOCKED: li = LIW'(2 * NUM_PRIORITIES + 1);
			default:          li = LIW'(2 * NUM_PRIORITIES + 2);
		endcase
		return li;
	endfunction

	logic [XW-1:0]  id_x;
	logic [IW-1:0]  idx;
	logic           id_ok;
	logic           prio_bad;
	logic [2:0]     cls;
	logic [LIW-1:0] li;
	logic [LW-1:0]  id_link;
	logic [LW-1:0]  ins_t;
	logic           ins_en;
	logic           un_en;
	logic [IW-1:0]  un_id;
	logic [LIW-1:0] un_li;
	logic [LW-1:0]  un_n;
	logic [LW-1:0]  un_p;
	logic           deq_found;
	logic [LIW-1:0] deq_li;
	logic [LW-1:0]  deq_head;
	logic [IW-1:0]  deq_idx;

	// Decode of the id, the class and the list the item names
	assign id_x     = XW'(item.proc_id);
	assign idx      = id_x[IW-1:0];
	assign id_ok    = {1'b0, id_x} < (XW + 1)'(NUM_PROCS);
	assign prio_bad = {1'b0, item.priority_req} >= 5'(NUM_PRIORITIES);
	assign cls      = class_of(item.exec_state, item.suspend_state);
	assign li       = list_of(cls, item.priority_req);
	assign id_link  = LW'(idx);
	assign ins_t    = tail_q[li];

	// Head search for dequeue: the lowest non-empty priority wins
	always_comb begin
		deq_found = 1'b0;
		deq_li    = '0;
		case (item.queue_class) inside
			CLS_READY, CLS_SUSP_READY: begin
				for (int p = NUM_PRIORITIES - 1; p >= 0; p--) begin
					if (head_q[list_of(item.queue_class, 4'(p))] != NIL) begin
						deq_found = 1'b1;
						deq_li    = list_of(item.queue_class, 4'(p));
					end
				end
			end
			CLS_BLOCKED, CLS_SUSP_BLOCKED, CLS_OTHER: begin
				deq_li    = list_of(item.queue_class, 4'd0);
				deq_found = head_q[deq_li] != NIL;
			end
			default: begin
				deq_found = 1'b0;
			end
		endcase
	end

	assign deq_head = head_q[deq_li];
	assign deq_idx  = deq_head[IW-1:0];

	// Operation decode and result
	always_comb begin
		result       = '0;
		result.status = ST_MISSING;
		ins_en       = 1'b0;
		un_en        = 1'b0;
		un_id        = idx;
		un_li        = li;
		unique case (item.kind) inside
			OP_INSERT, OP_REMOVE: begin
				if (prio_bad) begin
					result.status = ST_BAD_PRIO;
				end else if (id_ok) begin
					if (item.kind == OP_INSERT) begin
						if (valid_q[idx]) begin
							result.status = ST_DUPLICATE;
						end else begin
							ins_en        = 1'b1;
							result.status = ST_OK;
						end
					end else if (valid_q[idx] && list_of(cls_q[idx], prio_q[idx]) == li) begin
						un_en         = 1'b1;
						result.status = ST_OK;
					end
					if (result.status == ST_OK) begin
						result.out_proc_id  = item.proc_id;
						result.out_class    = cls;
						result.out_priority = item.priority_req;
					end
				end
			end
			OP_DEQUEUE: begin
				if (deq_found) begin
					un_en               = 1'b1;
					un_id               = deq_idx;
					un_li               = deq_li;
					result.status       = ST_OK;
					result.out_proc_id  = 4'(deq_head);
					result.out_class    = cls_q[deq_idx];
					result.out_priority = prio_q[deq_idx];
				end
			end
			OP_FIND: begin
				if (id_ok && valid_q[idx]) begin
					result.status       = ST_OK;
					result.out_proc_id  = item.proc_id;
					result.out_class    = cls_q[idx];
					result.out_priority = prio_q[idx];
				end
			end
		endcase
	end

	// Neighbours of the id being unlinked
	assign un_n = next_q[un_id];
	assign un_p = prev_q[un_id];

	// Valid bits, heads and tails
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < NUM_LISTS; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
			end
		end else if (fire) begin
			if (ins_en) begin
				valid_q[idx] <= 1'b1;
				if (ins_t == NIL)
					head_q[li] <= id_link;
				tail_q[li] <= id_link;
			end
			if (un_en) begin
				valid_q[un_id] <= 1'b0;
				if (un_p == NIL)
					head_q[un_li] <= un_n;
				if (un_n == NIL)
					tail_q[un_li] <= un_p;
			end
		end
	end

	// Entry payload and links
	always_ff @(posedge clk) begin
		if (fire) begin
			if (ins_en) begin
				cls_q[idx]  <= cls;
				prio_q[idx] <= item.priority_req;
				next_q[idx] <= NIL;
				prev_q[idx] <= ins_t;
				if (ins_t != NIL)
					next_q[ins_t[IW-1:0]] <= id_link;
			end
			if (un_en) begin
				if (un_p != NIL)
					next_q[un_p[IW-1:0]] <= un_n;
				if (un_n != NIL)
					prev_q[un_n[IW-1:0]] <= un_p;
			end
		end
	end

endmodule
